// ===== hw/rtl/dehp_pkg.sv =====
package dehp_pkg;

    // Depth of the queue between the parser and the output stage.
    localparam int QueueDepth = 4;

    // Value representation codes, in the order of the code table; VR_IMPLICIT marks
    // two bytes that match no known code.
    typedef enum logic [4:0] {
        VR_AE, VR_AS, VR_AT, VR_CS, VR_DA, VR_DS, VR_DT, VR_FL, VR_FD,
        VR_IS, VR_LO, VR_LT, VR_OB, VR_OW, VR_PN, VR_SH, VR_SL, VR_SQ,
        VR_SS, VR_ST, VR_TM, VR_UI, VR_UL, VR_UN, VR_US, VR_UT, VR_IMPLICIT
    } t_vr_code;

    // One result transaction.
    typedef struct packed {
        logic        is_header;
        logic [31:0] header_tag;
        t_vr_code    vr_code;
        logic [31:0] value_length;
        logic        no_value;
        logic [7:0]  value_byte;
        logic        last_value_byte;
    } t_result;

    // First character in bits 15..8, second in bits 7..0.
    function automatic t_vr_code vr_lookup(input logic [15:0] chars);
        t_vr_code code;
        case (chars)
            "AE":    code = VR_AE;
            "AS":    code = VR_AS;
            "AT":    code = VR_AT;
            "CS":    code = VR_CS;
            "DA":    code = VR_DA;
            "DS":    code = VR_DS;
            "DT":    code = VR_DT;
            "FL":    code = VR_FL;
            "FD":    code = VR_FD;
            "IS":    code = VR_IS;
            "LO":    code = VR_LO;
            "LT":    code = VR_LT;
            "OB":    code = VR_OB;
            "OW":    code = VR_OW;
            "PN":    code = VR_PN;
            "SH":    code = VR_SH;
            "SL":    code = VR_SL;
            "SQ":    code = VR_SQ;
            "SS":    code = VR_SS;
            "ST":    code = VR_ST;
            "TM":    code = VR_TM;
            "UI":    code = VR_UI;
            "UL":    code = VR_UL;
            "UN":    code = VR_UN;
            "US":    code = VR_US;
            "UT":    code = VR_UT;
            default: code = VR_IMPLICIT;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/dehp_front.sv =====
module dehp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    output logic              o_stall,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data_big_endian,
    input  logic              i_queue_full,
    output logic              o_push,
    output dehp_pkg::t_result o_push_item
);

    typedef enum logic [2:0] {
        PH_TAG, PH_VR, PH_RSV, PH_LEN4, PH_LEN2, PH_VAL
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [1:0]         r_byte_index, n_byte_index;
    logic               r_big_endian;
    logic [31:0]        r_tag, n_tag;
    logic [7:0]         r_vr_hi, n_vr_hi;
    dehp_pkg::t_vr_code r_vr_code, n_vr_code;
    logic [31:0]        r_len, n_len;
    logic [31:0]        r_remaining, n_remaining;

    logic               w_accept;
    logic               w_emit;
    logic [31:0]        w_len;
    logic [31:0]        w_rem;
    logic [1:0]         w_tag_idx;
    dehp_pkg::t_vr_code w_code;

    // Write byte b into byte lane ln of acc.
    function automatic logic [31:0] place(input logic [31:0] acc, input logic [7:0] b,
                                          input logic [1:0] ln);
        logic [31:0] res;
        res = acc;
        for (int k = 0; k < 4; k++) begin
            if (ln == 2'(k)) begin
                res[8*k +: 8] = b;
            end
        end
        return res;
    endfunction

    assign o_stall     = i_queue_full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && !i_queue_full;

    always_comb begin
        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_tag        = r_tag;
        n_vr_hi      = r_vr_hi;
        n_vr_code    = r_vr_code;
        n_len        = r_len;
        n_remaining  = r_remaining;
        o_push       = 1'b0;
        o_push_item  = '0;
        w_emit       = 1'b0;
        w_len        = r_len;
        w_rem        = r_remaining - 32'd1;
        w_code       = dehp_pkg::vr_lookup({r_vr_hi, i_data_byte});
        w_tag_idx    = (r_phase == PH_TAG) ? r_byte_index : 2'd0;

        if (w_accept) begin
            unique case (r_phase)
                PH_VR: begin
                    if (r_byte_index == 2'd0) begin
                        n_vr_hi      = i_data_byte;
                        n_byte_index = 2'd1;
                    end else begin
                        n_vr_code    = w_code;
                        n_byte_index = 2'd0;
                        n_len        = '0;
                        if (w_code == dehp_pkg::VR_IMPLICIT) begin
                            // VR bytes are the first half of a 4-byte length
                            n_len        = r_big_endian ? {r_vr_hi, i_data_byte, 16'h0000}
                                                        : {16'h0000, i_data_byte, r_vr_hi};
                            n_byte_index = 2'd2;
                            n_phase      = PH_LEN4;
                        end else if (w_code == dehp_pkg::VR_OB || w_code == dehp_pkg::VR_OW ||
                                     w_code == dehp_pkg::VR_SQ || w_code == dehp_pkg::VR_UN) begin
                            n_phase = PH_RSV;
                        end else begin
                            n_phase = PH_LEN2;
                        end
                    end
                end
                PH_RSV: begin
                    if (r_byte_index == 2'd0) begin
                        n_byte_index = 2'd1;
                    end else begin
                        n_byte_index = 2'd0;
                        n_len        = '0;
                        n_phase      = PH_LEN4;
                    end
                end
                PH_LEN4: begin
                    w_len        = place(r_len, i_data_byte,
                                         r_big_endian ? ~r_byte_index : r_byte_index);
                    n_len        = w_len;
                    n_byte_index = r_byte_index + 2'd1;
                    w_emit       = (r_byte_index == 2'd3);
                end
                PH_LEN2: begin
                    w_len        = place(r_len, i_data_byte,
                                         {1'b0, r_big_endian ^ r_byte_index[0]})
                                   & 32'h0000_FFFF;
                    n_len        = w_len;
                    n_byte_index = 2'd1;
                    w_emit       = r_byte_index[0];
                end
                PH_VAL: begin
                    o_push                      = 1'b1;
                    o_push_item.value_byte      = i_data_byte;
                    o_push_item.last_value_byte = (w_rem == '0);
                    n_remaining                 = w_rem;
                    if (w_rem == '0) begin
                        n_phase      = PH_TAG;
                        n_byte_index = 2'd0;
                    end
                end
                default: begin
                    // Tag phase; an unknown phase restarts the tag.
                    n_tag = place((w_tag_idx == 2'd0) ? 32'h0 : r_tag, i_data_byte,
                                  r_big_endian ? ~w_tag_idx : (w_tag_idx ^ 2'd2));
                    if (w_tag_idx == 2'd3) begin
                        n_byte_index = 2'd0;
                        n_phase      = PH_VR;
                    end else begin
                        n_byte_index = w_tag_idx + 2'd1;
                        n_phase      = PH_TAG;
                    end
                end
            endcase
        end

        if (w_emit) begin
            o_push                   = 1'b1;
            o_push_item.is_header    = 1'b1;
            o_push_item.header_tag   = r_tag;
            o_push_item.vr_code      = r_vr_code;
            o_push_item.value_length = w_len;
            o_push_item.no_value     = (w_len == '0) || (&w_len);
            n_byte_index             = 2'd0;
            if ((w_len == '0) || (&w_len)) begin
                n_phase = PH_TAG;
            end else begin
                n_remaining = w_len;
                n_phase     = PH_VAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_TAG;
            r_byte_index <= 2'd0;
            r_big_endian <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            if (i_cfg_valid) begin
                r_big_endian <= i_cfg_data_big_endian;
            end
        end
        r_tag       <= n_tag;
        r_vr_hi     <= n_vr_hi;
        r_vr_code   <= n_vr_code;
        r_len       <= n_len;
        r_remaining <= n_remaining;
    end

    a_val_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VAL) |-> (r_remaining != '0))
        else $error("value phase with no bytes left");

    a_empty_header_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_item.is_header && o_push_item.no_value) |=> (r_phase == PH_TAG))
        else $error("header without value did not return to tag phase");

    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> w_accept)
        else $error("push without an accepted byte");

endmodule

// ===== hw/rtl/dehp_queue.sv =====
module dehp_queue #(
    parameter int DEPTH = dehp_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  dehp_pkg::t_result i_item,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_not_empty,
    output dehp_pkg::t_result o_item
);

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    dehp_pkg::t_result r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0]   r_count;

    assign o_full      = (r_count == CntW'(DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CntW'(1);
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(DEPTH))
        else $error("queue count above depth");

    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_not_empty)
        else $error("pop from empty queue");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule

// ===== hw/rtl/dehp_back.sv =====
module dehp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_item_valid,
    input  dehp_pkg::t_result i_item,
    output logic              o_pop,
    input  logic              i_stall,
    output logic              o_valid,
    output dehp_pkg::t_result o_item
);

    logic              r_valid;
    dehp_pkg::t_result r_item;

    // Load the output register when it is empty or its transaction leaves now.
    assign o_pop   = i_item_valid && (!r_valid || !i_stall);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== hw/rtl/dicom_element_header_parser_core.sv =====
// DICOM element header parser: takes one stream byte per cycle and gives at most one result
// per byte, a header (tag, VR code, length) when a length field completes, then one result
// per value byte with the final one marked. Bytes are parsed combinationally and each result
// goes into a QUEUE_DEPTH-entry queue ahead of the output register, so it passes through the
// queue and then the output register. The input stalls only when that queue is full, which
// happens only after output stalls. Write the byte order while the stream is idle.
module dicom_element_header_parser_core #(
    parameter int QUEUE_DEPTH = dehp_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data_big_endian,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_header,
    output logic [31:0] o_header_tag,
    output logic [4:0]  o_vr_code,
    output logic [31:0] o_value_length,
    output logic        o_no_value,
    output logic [7:0]  o_value_byte,
    output logic        o_last_value_byte
);

    logic              w_queue_full;
    logic              w_push;
    dehp_pkg::t_result w_push_item;
    logic              w_not_empty;
    dehp_pkg::t_result w_queue_item;
    logic              w_pop;
    dehp_pkg::t_result w_out_item;

    dehp_front u_front (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .i_data_byte           (i_data_byte),
        .o_stall               (o_stall),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_data_big_endian (i_cfg_data_big_endian),
        .i_queue_full          (w_queue_full),
        .o_push                (w_push),
        .o_push_item           (w_push_item)
    );

    dehp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_item      (w_push_item),
        .i_pop       (w_pop),
        .o_full      (w_queue_full),
        .o_not_empty (w_not_empty),
        .o_item      (w_queue_item)
    );

    dehp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_not_empty),
        .i_item       (w_queue_item),
        .o_pop        (w_pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_item       (w_out_item)
    );

    assign o_is_header       = w_out_item.is_header;
    assign o_header_tag      = w_out_item.header_tag;
    assign o_vr_code         = w_out_item.vr_code;
    assign o_value_length    = w_out_item.value_length;
    assign o_no_value        = w_out_item.no_value;
    assign o_value_byte      = w_out_item.value_byte;
    assign o_last_value_byte = w_out_item.last_value_byte;

endmodule

// ===== verif/dicom_element_header_parser_core_tb.sv =====
`timescale 1ns / 100ps

module dicom_element_header_parser_core_tb;

    typedef enum logic [2:0] {
        ST_TAG, ST_VR, ST_RSV, ST_LEN4, ST_LEN2, ST_VAL
    } t_parse_state;

    // Two characters per VR, in code order.
    localparam logic [8*52-1:0] VR_NAMES =
        "AEASATCSDADSDTFLFDISLOLTOBOWPNSHSLSQSSSTTMUIULUNUSUT";
    localparam logic [31:0] LEN_UNDEFINED = 32'hFFFF_FFFF;
    localparam int LATENCY_PAD = dehp_pkg::QueueDepth + 8;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int HOLD_OFF_AFTER = 500;
    localparam int BURST_FIRST = 600;
    localparam int BURST_LAST = 850;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data_big_endian = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_is_header;
    logic [31:0] o_header_tag;
    logic [4:0]  o_vr_code;
    logic [31:0] o_value_length;
    logic        o_no_value;
    logic [7:0]  o_value_byte;
    logic        o_last_value_byte;

    dicom_element_header_parser_core dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_data_byte          (i_data_byte),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data_big_endian(i_cfg_data_big_endian),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_is_header          (o_is_header),
        .o_header_tag         (o_header_tag),
        .o_vr_code            (o_vr_code),
        .o_value_length       (o_value_length),
        .o_no_value           (o_no_value),
        .o_value_byte         (o_value_byte),
        .o_last_value_byte    (o_last_value_byte)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    logic [7:0]        stream_bytes[$];
    dehp_pkg::t_result expected_results[$];
    int                bytes_pushed = 0;
    int                bytes_accepted = 0;
    int                results_seen = 0;
    int                mismatch_count = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    bit                stream_big_endian = 1'b0;
    dehp_pkg::t_result oldest;

    // Parser state as the stream should leave it.
    bit           data_big_endian = 1'b0;
    t_parse_state parse_state = ST_TAG;
    logic [2:0]   field_pos = '0;
    logic [31:0]  tag_acc = '0;
    logic [15:0]  vr_chars = '0;
    logic [31:0]  len_acc = '0;
    logic [31:0]  bytes_left = '0;

    function automatic logic [7:0] vr_char(input dehp_pkg::t_vr_code code, input int k);
        return VR_NAMES[8 * (51 - 2 * int'(code) - k) +: 8];
    endfunction

    function automatic dehp_pkg::t_vr_code classify_vr(input logic [15:0] chars);
        for (int i = 0; i < 26; i++) begin
            if (vr_char(dehp_pkg::t_vr_code'(i), 0) == chars[15:8] &&
                vr_char(dehp_pkg::t_vr_code'(i), 1) == chars[7:0])
                return dehp_pkg::t_vr_code'(i);
        end
        return dehp_pkg::VR_IMPLICIT;
    endfunction

    function automatic bit has_long_length(input dehp_pkg::t_vr_code code);
        return code == dehp_pkg::VR_IMPLICIT || code == dehp_pkg::VR_OB
            || code == dehp_pkg::VR_OW || code == dehp_pkg::VR_SQ
            || code == dehp_pkg::VR_UN;
    endfunction

    function automatic logic [31:0] place_byte(input logic [31:0] acc, input logic [7:0] b,
                                               input int idx, input int n);
        int sh;
        sh = data_big_endian ? 8 * ((n - 1 - idx) & 3) : 8 * (idx & 3);
        acc[sh +: 8] = b;
        return acc;
    endfunction

    function automatic void emit_header(input logic [31:0] len);
        dehp_pkg::t_result r;
        r = '0;
        r.is_header = 1'b1;
        r.header_tag = tag_acc;
        r.vr_code = classify_vr(vr_chars);
        r.value_length = len;
        r.no_value = (len == 0 || len == LEN_UNDEFINED);
        expected_results.push_back(r);
        if (r.no_value) begin
            parse_state = ST_TAG;
        end else begin
            bytes_left = len;
            parse_state = ST_VAL;
        end
        field_pos = '0;
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        dehp_pkg::t_result  r;
        dehp_pkg::t_vr_code code;
        logic [1:0]         k;
        int                 sh;
        case (parse_state)
            ST_VR: begin
                if (field_pos == 0) begin
                    vr_chars = {b, 8'h00};
                    field_pos = 3'd1;
                end else begin
                    vr_chars[7:0] = b;
                    code = classify_vr(vr_chars);
                    field_pos = 3'd0;
                    len_acc = '0;
                    if (code == dehp_pkg::VR_IMPLICIT) begin
                        // the two VR bytes open a 4-byte length
                        len_acc = place_byte('0, vr_chars[15:8], 0, 4);
                        len_acc = place_byte(len_acc, b, 1, 4);
                        field_pos = 3'd2;
                        parse_state = ST_LEN4;
                    end else if (has_long_length(code)) begin
                        parse_state = ST_RSV;
                    end else begin
                        parse_state = ST_LEN2;
                    end
                end
            end
            ST_RSV: begin
                if (field_pos == 0) begin
                    field_pos = 3'd1;
                end else begin
                    field_pos = 3'd0;
                    len_acc = '0;
                    parse_state = ST_LEN4;
                end
            end
            ST_LEN4: begin
                len_acc = place_byte(len_acc, b, int'(field_pos[1:0]), 4);
                if (field_pos[1:0] == 2'd3)
                    emit_header(len_acc);
                else
                    field_pos = {1'b0, field_pos[1:0] + 2'd1};
            end
            ST_LEN2: begin
                len_acc = place_byte(len_acc, b, int'(field_pos[0]), 2) & 32'h0000_FFFF;
                if (field_pos[0])
                    emit_header(len_acc);
                else
                    field_pos = 3'd1;
            end
            ST_VAL: begin
                r = '0;
                r.value_byte = b;
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0) begin
                    r.last_value_byte = 1'b1;
                    parse_state = ST_TAG;
                    field_pos = 3'd0;
                end
                expected_results.push_back(r);
            end
            default: begin
                k = field_pos[1:0];
                // each 16-bit half follows the byte order, group half first
                if (data_big_endian)
                    sh = 24 - 8 * int'(k);
                else
                    sh = (k < 2 ? 16 : 0) + (k[0] ? 8 : 0);
                if (k == 0)
                    tag_acc = '0;
                tag_acc[sh +: 8] = b;
                if (k == 2'd3) begin
                    field_pos = 3'd0;
                    parse_state = ST_VR;
                end else begin
                    field_pos = {1'b0, k + 2'd1};
                end
            end
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] b);
        stream_bytes.push_back(b);
        bytes_pushed++;
    endtask

    task automatic push_field(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            push_byte(stream_big_endian ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8]);
    endtask

    task automatic push_head(input logic [31:0] tag, input dehp_pkg::t_vr_code code);
        push_field({16'h0000, tag[31:16]}, 2);
        push_field({16'h0000, tag[15:0]}, 2);
        if (code != dehp_pkg::VR_IMPLICIT) begin
            push_byte(vr_char(code, 0));
            push_byte(vr_char(code, 1));
        end
    endtask

    task automatic push_body(input dehp_pkg::t_vr_code code, input logic [31:0] len,
                             input int nvals);
        if (code == dehp_pkg::VR_IMPLICIT) begin
            push_field(len, 4);
        end else if (has_long_length(code)) begin
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
            push_field(len, 4);
        end else begin
            push_field({16'h0000, len[15:0]}, 2);
        end
        repeat (nvals) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic add_element(input logic [31:0] tag, input dehp_pkg::t_vr_code code,
                               input logic [31:0] len, input int nvals);
        push_head(tag, code);
        push_body(code, len, nvals);
    endtask

    task automatic add_directed();
        add_element(32'h0000_0000, dehp_pkg::VR_AE, 32'd1, 1);
        add_element(32'hFFFF_FFFF, dehp_pkg::VR_IMPLICIT, 32'd2, 2);
        add_element(32'h7FE0_0010, dehp_pkg::VR_OB, LEN_UNDEFINED, 0);
        add_element(32'h0010_0010, dehp_pkg::VR_PN, 32'd0, 0);
    endtask

    // Whole elements with random tag, VR and length; lengths stay small or undefined so the
    // implicit ones never spell a known VR.
    task automatic add_random(input int n_bytes);
        int                 start;
        int                 roll;
        dehp_pkg::t_vr_code code;
        logic [31:0]        len;
        start = bytes_pushed;
        while (bytes_pushed - start < n_bytes) begin
            code = dehp_pkg::t_vr_code'($urandom_range(0, 26));
            roll = $urandom_range(0, 99);
            if (roll < 8)
                len = 0;
            else if (roll < 15 && has_long_length(code))
                len = LEN_UNDEFINED;
            else if (roll < 22)
                len = $urandom_range(7, 24);
            else
                len = $urandom_range(1, 6);
            add_element($urandom, code, len,
                        (len == 0 || len == LEN_UNDEFINED) ? 0 : int'(len));
        end
    endtask

    task automatic wait_idle();
        while (bytes_accepted != bytes_pushed || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic write_byte_order(input bit big_endian);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data_big_endian <= big_endian;
        do @(posedge i_clk); while (!o_cfg_ready);
        data_big_endian = big_endian;
        stream_big_endian = big_endian;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Byte sender: hold a stalled transaction, otherwise offer the next byte or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_data_byte);
                bytes_accepted++;
            end
            if (!(i_valid && o_stall)) begin
                if (stream_bytes.size() != 0 &&
                    ((bytes_accepted >= BURST_FIRST && bytes_accepted < BURST_LAST) ||
                     $urandom_range(0, 99) >= 20)) begin
                    i_valid <= 1'b1;
                    i_data_byte <= stream_bytes.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatch_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("is_header", 32'(oldest.is_header), 32'(o_is_header));
                    check_field("header_tag", oldest.header_tag, o_header_tag);
                    check_field("vr_code", 32'(oldest.vr_code), 32'(o_vr_code));
                    check_field("value_length", oldest.value_length, o_value_length);
                    check_field("no_value", 32'(oldest.no_value), 32'(o_no_value));
                    check_field("value_byte", 32'(oldest.value_byte), 32'(o_value_byte));
                    check_field("last_value_byte", 32'(oldest.last_value_byte),
                                32'(o_last_value_byte));
                end
            end
            if (hold_left != 0) begin
                i_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end else if (!hold_done && results_seen >= HOLD_OFF_AFTER) begin
                // back up the output so the input side fills and stalls
                hold_done <= 1'b1;
                hold_left <= HOLD_OFF_CYCLES;
                i_stall <= 1'b1;
            end else if (results_seen >= BURST_FIRST && results_seen < BURST_LAST) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 20);
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_byte_order(1'b0);
        add_directed();
        wait_idle();

        write_byte_order(1'b1);
        add_directed();
        add_random(240);
        wait_idle();

        write_byte_order(1'b0);
        add_random(240);
        // stop inside a header and switch byte order before its length
        push_head($urandom, dehp_pkg::VR_OB);
        wait_idle();
        write_byte_order(1'b1);
        push_body(dehp_pkg::VR_OB, 32'd5, 5);
        add_random(240);
        wait_idle();

        write_byte_order(1'b0);
        add_random(240);
        wait_idle();

        write_byte_order(1'b1);
        add_random(200);
        // unstructured bytes last: they may open an element that never completes
        repeat (100) push_byte(8'($urandom_range(0, 255)));
        wait_idle();

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("dicom_element_header_parser_core test passed");
        else
            $display("dicom_element_header_parser_core test failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("dicom_element_header_parser_core test failed");
        $finish;
    end

endmodule
